FILE: sv/refcounted_entry_table_top_defines.svh
// Assertion macros for the modules of the entry table; ret_ctrl is the module that uses them.
// Each macro expects signals named clk and rst_n in the module that uses it.
`ifndef REFCOUNTED_ENTRY_TABLE_TOP_DEFINES_SVH
`define REFCOUNTED_ENTRY_TABLE_TOP_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define RET_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define RET_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: sv/ret_pkg.sv
package ret_pkg;

  localparam int TABLE_ENTRIES = 16;
  localparam int MOUNT_ENTRIES = 2;
  localparam int ROOT_NUMBER   = 1;

  localparam int IDX_W  = $clog2(TABLE_ENTRIES);
  localparam int SLOT_W = 4;
  localparam int DEV_W  = 16;
  localparam int NUM_W  = 16;
  localparam int CNT_W  = 8;
  localparam int STAT_W = 3;
  localparam int CMP_W  = ((IDX_W > SLOT_W) ? IDX_W : SLOT_W) + 1;
  localparam int RED_W  = 2;
  localparam int ADDR_W = 5;
  localparam int DATA_W = 32;

  typedef enum logic [STAT_W-1:0] {
    ST_HIT  = 3'd0,
    ST_LOAD = 3'd1,
    ST_FULL = 3'd2,
    ST_REL  = 3'd3,
    ST_LAST = 3'd4,
    ST_BAD  = 3'd5,
    ST_OVF  = 3'd6
  } status_code_t;

  typedef enum logic [2:0] {
    REG_A_VALID  = 3'd0,
    REG_A_SLOT   = 3'd1,
    REG_A_DEVICE = 3'd2,
    REG_B_VALID  = 3'd3,
    REG_B_SLOT   = 3'd4,
    REG_B_DEVICE = 3'd5
  } reg_idx_t;

  typedef struct packed {
    logic              valid;
    logic [SLOT_W-1:0] slot;
    logic [DEV_W-1:0]  device;
  } mount_t;

  typedef struct packed {
    logic [DEV_W-1:0] device;
    logic [NUM_W-1:0] number;
    logic [CNT_W-1:0] count;
  } entry_t;

  typedef struct packed {
    logic         load_in;
    logic         scan_clr;
    logic         scan_en;
    logic         redirect;
    logic         rd_rel;
    logic         wr_hit;
    logic         wr_alloc;
    logic         wr_last;
    logic         wr_dec;
    logic         out_load;
    status_code_t code;
  } cmd_t;

  typedef struct packed {
    logic scan_last;
    logic hit_found;
    logic hit_mount;
    logic loop;
    logic cnt_max;
    logic free_found;
    logic rel_bad;
    logic cnt_zero;
    logic cnt_one;
    logic out_free;
  } stat_t;

endpackage

FILE: sv/ret_regs.sv
module ret_regs
  import ret_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [ADDR_W-1:0]      paddr,
  input  logic [DATA_W-1:0]      pwdata,
  output logic [DATA_W-1:0]      prdata,
  output logic                   pready,
  output mount_t [1:0]           mounts
);

  mount_t [1:0] mounts_r;
  reg_idx_t     reg_idx;

  assign reg_idx = reg_idx_t'(paddr[4:2]);
  assign pready  = 1'b1;
  assign mounts  = mounts_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mounts_r <= '0;
    end else if (psel && penable && pwrite && pready) begin
      case (reg_idx)
        REG_A_VALID:  mounts_r[0].valid  <= pwdata[0];
        REG_A_SLOT:   mounts_r[0].slot   <= pwdata[SLOT_W-1:0];
        REG_A_DEVICE: mounts_r[0].device <= pwdata[DEV_W-1:0];
        REG_B_VALID:  mounts_r[1].valid  <= pwdata[0];
        REG_B_SLOT:   mounts_r[1].slot   <= pwdata[SLOT_W-1:0];
        REG_B_DEVICE: mounts_r[1].device <= pwdata[DEV_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_A_VALID:  prdata = DATA_W'(mounts_r[0].valid);
      REG_A_SLOT:   prdata = DATA_W'(mounts_r[0].slot);
      REG_A_DEVICE: prdata = DATA_W'(mounts_r[0].device);
      REG_B_VALID:  prdata = DATA_W'(mounts_r[1].valid);
      REG_B_SLOT:   prdata = DATA_W'(mounts_r[1].slot);
      REG_B_DEVICE: prdata = DATA_W'(mounts_r[1].device);
      default:      prdata = '0;
    endcase
  end

endmodule

FILE: sv/ret_dp.sv
module ret_dp
  import ret_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  cmd_t               cmd,
  output stat_t              st,
  input  mount_t [1:0]       mounts,
  input  logic               in_kind,
  input  logic [DEV_W-1:0]   in_device,
  input  logic [NUM_W-1:0]   in_number,
  input  logic [SLOT_W-1:0]  in_release_slot,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [STAT_W-1:0]  out_status,
  output logic [SLOT_W-1:0]  out_slot,
  output logic [DEV_W-1:0]   out_final_device,
  output logic [NUM_W-1:0]   out_final_number
);

  entry_t                  mem [TABLE_ENTRIES];
  logic [TABLE_ENTRIES-1:0] valid_r;
  entry_t                  rd_r;

  logic                    kind_r;
  logic [DEV_W-1:0]        cur_dev_r;
  logic [NUM_W-1:0]        cur_num_r;
  logic [SLOT_W-1:0]       rs_r;
  logic [RED_W-1:0]        redirects_r;

  logic [IDX_W-1:0]        scan_addr_r;
  logic                    cmp_vld_r;
  logic [IDX_W-1:0]        cmp_idx_r;
  logic                    hit_found_r;
  logic [IDX_W-1:0]        hit_idx_r;
  logic [CNT_W-1:0]        hit_cnt_r;
  logic                    free_found_r;
  logic [IDX_W-1:0]        free_idx_r;

  logic                    out_valid_r;
  logic [STAT_W-1:0]       out_status_r;
  logic [SLOT_W-1:0]       out_slot_r;
  logic [DEV_W-1:0]        out_dev_r;
  logic [NUM_W-1:0]        out_num_r;

  logic [IDX_W-1:0]        rs_idx;
  logic                    rel_bad;
  logic [IDX_W-1:0]        rd_addr;
  logic                    hit_mount;
  logic [DEV_W-1:0]        mnt_dev;
  logic                    wr_en;
  logic [IDX_W-1:0]        wr_addr;
  entry_t                  wr_data;
  logic [SLOT_W-1:0]       slot_nxt;
  logic [DEV_W-1:0]        dev_nxt;
  logic [NUM_W-1:0]        num_nxt;

  assign rs_idx  = IDX_W'(CMP_W'(rs_r));
  assign rel_bad = CMP_W'(rs_r) >= CMP_W'(TABLE_ENTRIES);
  assign rd_addr = cmd.rd_rel ? rs_idx : scan_addr_r;

  always_comb begin
    hit_mount = 1'b0;
    mnt_dev   = '0;
    for (int m = MOUNT_ENTRIES - 1; m >= 0; m--) begin
      if (mounts[m].valid && CMP_W'(mounts[m].slot) == CMP_W'(hit_idx_r)) begin
        hit_mount = 1'b1;
        mnt_dev   = mounts[m].device;
      end
    end
  end

  always_comb begin
    wr_en   = 1'b1;
    wr_addr = hit_idx_r;
    wr_data = '{device: cur_dev_r, number: cur_num_r, count: hit_cnt_r + CNT_W'(1)};
    if (cmd.wr_alloc) begin
      wr_addr = free_idx_r;
      wr_data = '{device: cur_dev_r, number: cur_num_r, count: CNT_W'(1)};
    end else if (cmd.wr_last) begin
      wr_addr = rs_idx;
      wr_data = '{device: rd_r.device, number: '0, count: '0};
    end else if (cmd.wr_dec) begin
      wr_addr = rs_idx;
      wr_data = '{device: rd_r.device, number: rd_r.number, count: rd_r.count - CNT_W'(1)};
    end else if (!cmd.wr_hit) begin
      wr_en = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_r <= valid_r[rd_addr] ? mem[rd_addr] : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (wr_en) begin
      valid_r[wr_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      kind_r      <= in_kind;
      cur_dev_r   <= in_device;
      cur_num_r   <= in_number;
      rs_r        <= in_release_slot;
      redirects_r <= '0;
    end else if (cmd.redirect) begin
      cur_dev_r   <= mnt_dev;
      cur_num_r   <= NUM_W'(ROOT_NUMBER);
      redirects_r <= redirects_r + RED_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cmp_vld_r    <= 1'b0;
      hit_found_r  <= 1'b0;
      free_found_r <= 1'b0;
      scan_addr_r  <= '0;
    end else if (cmd.scan_clr) begin
      cmp_vld_r    <= 1'b0;
      hit_found_r  <= 1'b0;
      free_found_r <= 1'b0;
      scan_addr_r  <= '0;
    end else begin
      cmp_vld_r <= cmd.scan_en;
      if (cmd.scan_en) begin
        scan_addr_r <= scan_addr_r + IDX_W'(1);
      end
      if (cmp_vld_r) begin
        if (!hit_found_r && rd_r.device == cur_dev_r && rd_r.number == cur_num_r) begin
          hit_found_r <= 1'b1;
        end
        if (!free_found_r && rd_r.count == '0) begin
          free_found_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    cmp_idx_r <= scan_addr_r;
    if (cmp_vld_r && !hit_found_r && rd_r.device == cur_dev_r
        && rd_r.number == cur_num_r) begin
      hit_idx_r <= cmp_idx_r;
      hit_cnt_r <= rd_r.count;
    end
    if (cmp_vld_r && !free_found_r && rd_r.count == '0) begin
      free_idx_r <= cmp_idx_r;
    end
  end

  always_comb begin
    if (kind_r) begin
      slot_nxt = rs_r;
      dev_nxt  = rel_bad ? '0 : rd_r.device;
      num_nxt  = rel_bad ? '0 : rd_r.number;
    end else begin
      dev_nxt = cur_dev_r;
      num_nxt = cur_num_r;
      case (cmd.code)
        ST_LOAD: slot_nxt = SLOT_W'(CMP_W'(free_idx_r));
        ST_FULL: slot_nxt = '0;
        default: slot_nxt = SLOT_W'(CMP_W'(hit_idx_r));
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_status_r <= cmd.code;
      out_slot_r   <= slot_nxt;
      out_dev_r    <= dev_nxt;
      out_num_r    <= num_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_status       = out_status_r;
  assign out_slot         = out_slot_r;
  assign out_final_device = out_dev_r;
  assign out_final_number = out_num_r;

  assign st.scan_last  = scan_addr_r == IDX_W'(TABLE_ENTRIES - 1);
  assign st.hit_found  = hit_found_r;
  assign st.hit_mount  = hit_mount;
  assign st.loop       = CMP_W'(redirects_r) >= CMP_W'(MOUNT_ENTRIES);
  assign st.cnt_max    = &hit_cnt_r;
  assign st.free_found = free_found_r;
  assign st.rel_bad    = rel_bad;
  assign st.cnt_zero   = rd_r.count == '0;
  assign st.cnt_one    = rd_r.count == CNT_W'(1);
  assign st.out_free   = !out_valid_r || !out_stall;

endmodule

FILE: sv/ret_ctrl.sv
`include "refcounted_entry_table_top_defines.svh"

module ret_ctrl
  import ret_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_valid,
  input  logic  in_kind,
  output logic  in_stall,
  input  stat_t st,
  output cmd_t  cmd
);

  typedef enum logic [6:0] {
    S_IDLE    = 7'b0000001,
    S_SCAN    = 7'b0000010,
    S_DRAIN   = 7'b0000100,
    S_DECIDE  = 7'b0001000,
    S_REL_RD  = 7'b0010000,
    S_REL_DEC = 7'b0100000,
    S_SPARE   = 7'b1000000
  } state_t;

  state_t     state_r;
  state_t     state_nxt;
  logic [3:0] wr_vec;

  assign in_stall = state_r != S_IDLE;
  assign wr_vec   = {cmd.wr_hit, cmd.wr_alloc, cmd.wr_last, cmd.wr_dec};

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_in  = 1'b1;
          cmd.scan_clr = 1'b1;
          state_nxt    = in_kind ? S_REL_RD : S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.scan_en = 1'b1;
        if (st.scan_last) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        state_nxt = S_DECIDE;
      end
      S_DECIDE: begin
        if (st.hit_found && st.hit_mount && !st.loop) begin
          cmd.redirect = 1'b1;
          cmd.scan_clr = 1'b1;
          state_nxt    = S_SCAN;
        end else if (st.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
          if (st.hit_found) begin
            if (st.hit_mount || st.cnt_max) begin
              cmd.code = ST_OVF;
            end else begin
              cmd.code   = ST_HIT;
              cmd.wr_hit = 1'b1;
            end
          end else if (st.free_found) begin
            cmd.code     = ST_LOAD;
            cmd.wr_alloc = 1'b1;
          end else begin
            cmd.code = ST_FULL;
          end
        end
      end
      S_REL_RD: begin
        cmd.rd_rel = 1'b1;
        state_nxt  = S_REL_DEC;
      end
      S_REL_DEC: begin
        cmd.rd_rel = 1'b1;
        if (st.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
          if (st.rel_bad || st.cnt_zero) begin
            cmd.code = ST_BAD;
          end else if (st.cnt_one) begin
            cmd.code    = ST_LAST;
            cmd.wr_last = 1'b1;
          end else begin
            cmd.code   = ST_REL;
            cmd.wr_dec = 1'b1;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  `RET_ASSERT_SAME(a_wr_onehot, 1'b1, $onehot0(wr_vec), "More than one table write at once.")
  `RET_ASSERT_SAME(a_wr_with_out, wr_vec != 4'd0, cmd.out_load, "Table write without a result.")
  `RET_ASSERT_NEXT(a_acq_scan, state_r == S_IDLE && in_valid && !in_kind, state_r == S_SCAN,
                   "Acquire request did not start a scan.")
  `RET_ASSERT_SAME(a_redirect_bound, cmd.redirect, !st.loop, "Redirect past the mount limit.")

endmodule

FILE: sv/refcounted_entry_table_top.sv
// Reference-counted entry table with mount redirection. A request is taken only while the
// block is idle and always yields exactly one result. A release reads its entry in S_REL_RD
// and loads the result register in S_REL_DEC. An acquire scans the table through its single
// read port at one entry per cycle, and each mount redirection adds another lookup pass
// over the table, so an acquire takes one, two or three passes. No request of either kind
// is accepted before the previous one has loaded its result. A new request is accepted
// while the previous result still waits in the output register; the next result then waits
// in its final state until the output register frees, so output stall beyond that delays
// the request. Mount registers lie at byte addresses 0 to 20 of the configuration port.
module refcounted_entry_table_top
  import ret_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               in_kind,
  input  logic [DEV_W-1:0]   in_device,
  input  logic [NUM_W-1:0]   in_number,
  input  logic [SLOT_W-1:0]  in_release_slot,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [STAT_W-1:0]  out_status,
  output logic [SLOT_W-1:0]  out_slot,
  output logic [DEV_W-1:0]   out_final_device,
  output logic [NUM_W-1:0]   out_final_number,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [ADDR_W-1:0]  paddr,
  input  logic [DATA_W-1:0]  pwdata,
  output logic [DATA_W-1:0]  prdata,
  output logic               pready
);

  mount_t [1:0] mounts;
  cmd_t         cmd;
  stat_t        st;

  ret_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .mounts  (mounts)
  );

  ret_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_kind  (in_kind),
    .in_stall (in_stall),
    .st       (st),
    .cmd      (cmd)
  );

  ret_dp u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .st               (st),
    .mounts           (mounts),
    .in_kind          (in_kind),
    .in_device        (in_device),
    .in_number        (in_number),
    .in_release_slot  (in_release_slot),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_status       (out_status),
    .out_slot         (out_slot),
    .out_final_device (out_final_device),
    .out_final_number (out_final_number)
  );

endmodule

FILE: dv/tb_refcounted_entry_table_top.sv
module tb_refcounted_entry_table_top;
  timeunit 1ns;
  timeprecision 1ps;

  import ret_pkg::*;

  localparam int   IDLE_LIMIT    = 2000;
  localparam int   DRAIN_CYCLES  = 64;
  localparam int   RANDOM_ITEMS  = 175;
  localparam int   RANDOM_PHASES = 5;
  localparam logic KIND_ACQUIRE  = 1'b0;
  localparam logic KIND_RELEASE  = 1'b1;

  typedef struct {
    status_code_t      status;
    logic [SLOT_W-1:0] slot;
    logic [DEV_W-1:0]  device;
    logic [NUM_W-1:0]  number;
  } table_result_t;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_stall;
  logic               in_kind;
  logic [DEV_W-1:0]   in_device;
  logic [NUM_W-1:0]   in_number;
  logic [SLOT_W-1:0]  in_release_slot;
  logic               out_valid;
  logic               out_stall;
  logic [STAT_W-1:0]  out_status;
  logic [SLOT_W-1:0]  out_slot;
  logic [DEV_W-1:0]   out_final_device;
  logic [NUM_W-1:0]   out_final_number;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [ADDR_W-1:0]  paddr;
  logic [DATA_W-1:0]  pwdata;
  logic [DATA_W-1:0]  prdata;
  logic               pready;

  logic [DEV_W-1:0] tbl_device [TABLE_ENTRIES];
  logic [NUM_W-1:0] tbl_number [TABLE_ENTRIES];
  logic [CNT_W-1:0] tbl_count  [TABLE_ENTRIES];
  mount_t           mounts     [2];

  table_result_t pending_results [$];
  int mismatches      = 0;
  int requests_sent   = 0;
  int results_checked = 0;
  int status_seen [8] = '{default: 0};
  int quiet_cycles    = 0;
  int stall_left      = 0;
  logic idle_on       = 1'b1;

  refcounted_entry_table_top uut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_kind          (in_kind),
    .in_device        (in_device),
    .in_number        (in_number),
    .in_release_slot  (in_release_slot),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_status       (out_status),
    .out_slot         (out_slot),
    .out_final_device (out_final_device),
    .out_final_number (out_final_number),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready)
  );

  always #5 clk = ~clk;

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] exp);
    $display("ERROR at %0t: %s is 0x%0h, expected 0x%0h", $time, what, got, exp);
    mismatches++;
  endtask

  // Works out the result of one request and updates the table copy, in acceptance order.
  function automatic table_result_t predict_request(logic kind, logic [DEV_W-1:0] dev,
                                                    logic [NUM_W-1:0] num,
                                                    logic [SLOT_W-1:0] rel);
    table_result_t r;
    int hit;
    int free_idx;
    int mnt;
    int redirects;
    logic done;
    redirects = 0;
    done = 1'b0;
    r = '{status: ST_BAD, slot: rel, device: '0, number: '0};
    if (kind == KIND_RELEASE) begin
      if (int'(rel) >= TABLE_ENTRIES) return r;
      r.device = tbl_device[rel];
      r.number = tbl_number[rel];
      if (tbl_count[rel] == 0) begin
        r.status = ST_BAD;
      end else if (tbl_count[rel] == 1) begin
        tbl_number[rel] = '0;
        tbl_count[rel] = '0;
        r.status = ST_LAST;
      end else begin
        tbl_count[rel] = tbl_count[rel] - 1'b1;
        r.status = ST_REL;
      end
      return r;
    end
    while (!done) begin
      hit = -1;
      free_idx = -1;
      for (int i = 0; i < TABLE_ENTRIES; i++) begin
        if (hit < 0) begin
          if (tbl_device[i] == dev && tbl_number[i] == num) hit = i;
          else if (free_idx < 0 && tbl_count[i] == 0) free_idx = i;
        end
      end
      r.device = dev;
      r.number = num;
      if (hit < 0) begin
        done = 1'b1;
        if (free_idx < 0) begin
          r.status = ST_FULL;
          r.slot = '0;
        end else begin
          tbl_device[free_idx] = dev;
          tbl_number[free_idx] = num;
          tbl_count[free_idx] = CNT_W'(1);
          r.status = ST_LOAD;
          r.slot = free_idx[SLOT_W-1:0];
        end
      end else begin
        mnt = -1;
        for (int m = MOUNT_ENTRIES - 1; m >= 0; m--) begin
          if (mounts[m].valid && int'(mounts[m].slot) == hit) mnt = m;
        end
        r.slot = hit[SLOT_W-1:0];
        if (mnt >= 0 && redirects < MOUNT_ENTRIES) begin
          redirects++;
          dev = mounts[mnt].device;
          num = NUM_W'(ROOT_NUMBER);
        end else begin
          done = 1'b1;
          if (mnt >= 0 || tbl_count[hit] == '1) begin
            r.status = ST_OVF;
          end else begin
            tbl_count[hit] = tbl_count[hit] + 1'b1;
            r.status = ST_HIT;
          end
        end
      end
    end
    return r;
  endfunction

  always @(posedge clk) begin
    table_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      results_checked++;
      status_seen[out_status]++;
      if (pending_results.size() == 0) begin
        report_mismatch("status of a result with no request waiting", out_status, '0);
      end else begin
        want = pending_results.pop_front();
        if (out_status !== want.status) report_mismatch("status", out_status, want.status);
        if (out_slot !== want.slot) report_mismatch("slot", out_slot, want.slot);
        if (out_final_device !== want.device)
          report_mismatch("final_device", out_final_device, want.device);
        if (out_final_number !== want.number)
          report_mismatch("final_number", out_final_number, want.number);
      end
    end
  end

  always @(negedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_stall <= 1'b1;
    end else if (idle_on && $urandom_range(0, 7) == 0) begin
      stall_left <= $urandom_range(0, 7);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= IDLE_LIMIT) begin
      $display("TIMEOUT at %0t: no handshake for %0d cycles", $time, IDLE_LIMIT);
      $display("Mismatches found");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_request(logic kind, logic [DEV_W-1:0] dev, logic [NUM_W-1:0] num,
                              logic [SLOT_W-1:0] rel);
    int gap;
    gap = (idle_on && $urandom_range(0, 4) == 0) ? $urandom_range(1, 8) : 0;
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_kind <= kind;
    in_device <= dev;
    in_number <= num;
    in_release_slot <= rel;
    do @(posedge clk); while (in_stall);
    pending_results.push_back(predict_request(kind, dev, num, rel));
    requests_sent++;
  endtask

  task automatic wait_all_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
  endtask

  task automatic write_mount_reg(reg_idx_t idx, logic [DATA_W-1:0] value);
    logic [DATA_W-1:0] readback;
    logic [DATA_W-1:0] mask;
    int m;
    m = (idx >= REG_B_VALID) ? 1 : 0;
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= ADDR_W'({idx, 2'b00});
    pwdata <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(negedge clk);
    psel <= 1'b1;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    readback = prdata;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    case (idx)
      REG_A_VALID, REG_B_VALID: begin
        mounts[m].valid = value[0];
        mask = 32'h1;
      end
      REG_A_SLOT, REG_B_SLOT: begin
        mounts[m].slot = value[SLOT_W-1:0];
        mask = 32'hF;
      end
      default: begin
        mounts[m].device = value[DEV_W-1:0];
        mask = 32'hFFFF;
      end
    endcase
    if ((readback & mask) != (value & mask))
      report_mismatch("register readback", readback & mask, value & mask);
  endtask

  task automatic set_mount(int m, logic valid, logic [SLOT_W-1:0] slot,
                           logic [DEV_W-1:0] dev);
    write_mount_reg(m == 0 ? REG_A_VALID : REG_B_VALID, DATA_W'(valid));
    write_mount_reg(m == 0 ? REG_A_SLOT : REG_B_SLOT, DATA_W'(slot));
    write_mount_reg(m == 0 ? REG_A_DEVICE : REG_B_DEVICE, DATA_W'(dev));
  endtask

  task automatic release_all_entries();
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      while (tbl_count[i] != 0)
        send_request(KIND_RELEASE, DEV_W'($urandom_range(0, 16'hFFFF)),
                     NUM_W'($urandom_range(0, 16'hFFFF)), SLOT_W'(i));
    end
  endtask

  // Fresh entries all read (0, 0), so the first acquire of that pair hits a zero count.
  task automatic test_basic_requests();
    send_request(KIND_ACQUIRE, 16'h0000, 16'h0000, 4'hF);
    send_request(KIND_ACQUIRE, 16'h0000, 16'h0000, 4'h0);
    send_request(KIND_RELEASE, 16'hFFFF, 16'hFFFF, 4'h0);
    send_request(KIND_RELEASE, 16'h0000, 16'h0000, 4'h0);
    send_request(KIND_RELEASE, 16'h0000, 16'h0000, 4'hF);
    send_request(KIND_ACQUIRE, 16'hFFFF, 16'hFFFF, 4'h0);
    send_request(KIND_ACQUIRE, 16'hFFFF, 16'hFFFF, 4'hF);
    send_request(KIND_ACQUIRE, 16'hFFFF, 16'h0000, 4'h0);
    send_request(KIND_ACQUIRE, 16'h0000, 16'hFFFF, 4'h0);
    send_request(KIND_RELEASE, 16'h0000, 16'h0000, 4'h2);
    send_request(KIND_ACQUIRE, 16'h0000, 16'h0000, 4'h0);
    send_request(KIND_RELEASE, 16'hAAAA, 16'h5555, 4'h2);
    send_request(KIND_RELEASE, 16'h5555, 16'hAAAA, 4'h1);
    send_request(KIND_RELEASE, 16'h0000, 16'h0000, 4'h0);
    send_request(KIND_RELEASE, 16'h0000, 16'h0000, 4'h0);
    send_request(KIND_RELEASE, 16'h0000, 16'h0000, 4'h0);
    wait_all_results();
  endtask

  task automatic test_table_full();
    release_all_entries();
    for (int k = 0; k <= TABLE_ENTRIES; k++)
      send_request(KIND_ACQUIRE, 16'h5A5A, NUM_W'(k), 4'h0);
    send_request(KIND_ACQUIRE, 16'h5A5A, 16'h0003, 4'h0);
    release_all_entries();
    wait_all_results();
  endtask

  task automatic test_mount_redirect();
    release_all_entries();
    send_request(KIND_ACQUIRE, 16'h0100, 16'h0007, 4'h0);
    wait_all_results();
    set_mount(0, 1'b1, 4'd0, 16'h0200);
    send_request(KIND_ACQUIRE, 16'h0100, 16'h0007, 4'h0);
    send_request(KIND_ACQUIRE, 16'h0100, 16'h0007, 4'h0);
    wait_all_results();
    // Both mounts cover the same entry; the first one must win.
    set_mount(1, 1'b1, 4'd0, 16'h0300);
    send_request(KIND_ACQUIRE, 16'h0100, 16'h0007, 4'h0);
    wait_all_results();
    set_mount(1, 1'b1, 4'd1, 16'hFFFF);
    send_request(KIND_ACQUIRE, 16'h0100, 16'h0007, 4'h0);
    wait_all_results();
    // A mount whose root lands on its own entry loops until the redirect limit.
    set_mount(1, 1'b1, 4'd2, 16'hFFFF);
    send_request(KIND_ACQUIRE, 16'hFFFF, 16'h0001, 4'h0);
    send_request(KIND_ACQUIRE, 16'h0100, 16'h0007, 4'h0);
    wait_all_results();
    set_mount(0, 1'b1, 4'd15, 16'h0000);
    set_mount(1, 1'b0, 4'd15, 16'hFFFF);
    send_request(KIND_ACQUIRE, 16'h0000, 16'h0000, 4'h0);
    send_request(KIND_ACQUIRE, 16'h0000, 16'h0001, 4'h0);
    send_request(KIND_ACQUIRE, 16'hFFFF, 16'h0001, 4'h0);
    wait_all_results();
    set_mount(0, 1'b0, 4'd0, 16'h0000);
    release_all_entries();
    wait_all_results();
  endtask

  task automatic test_count_overflow();
    release_all_entries();
    for (int k = 0; k <= 1 << CNT_W; k++)
      send_request(KIND_ACQUIRE, 16'h7777, 16'h4242, 4'h0);
    release_all_entries();
    wait_all_results();
  endtask

  task automatic test_random_traffic();
    logic [DEV_W-1:0] pool_dev [4];
    logic [DEV_W-1:0] dev;
    logic [NUM_W-1:0] num;
    int pick;
    pool_dev = '{16'h0000, 16'hFFFF, 16'h00A0, 16'h00A1};
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      wait_all_results();
      idle_on = (phase < RANDOM_PHASES - 1);
      if (phase == 0) begin
        set_mount(0, 1'b1, 4'd0, 16'h0000);
        set_mount(1, 1'b1, 4'd15, 16'hFFFF);
      end else begin
        set_mount(0, 1'($urandom_range(0, 1)), SLOT_W'($urandom_range(0, 15)),
                  pool_dev[$urandom_range(0, 3)]);
        set_mount(1, 1'($urandom_range(0, 1)), SLOT_W'($urandom_range(0, 15)),
                  pool_dev[$urandom_range(0, 3)]);
      end
      for (int n = 0; n < RANDOM_ITEMS / RANDOM_PHASES; n++) begin
        if (n > 0 && n % 50 == 0) wait_all_results();
        pick = $urandom_range(0, 99);
        dev = DEV_W'($urandom_range(0, 16'hFFFF));
        num = NUM_W'($urandom_range(0, 16'hFFFF));
        if (pick < 40) begin
          send_request(KIND_RELEASE, dev, num, SLOT_W'($urandom_range(0, 15)));
        end else begin
          if (pick >= 50) begin
            dev = pool_dev[$urandom_range(0, 3)];
            case ($urandom_range(0, 3))
              0: num = '0;
              1: num = NUM_W'(ROOT_NUMBER);
              2: num = 16'h0002;
              default: num = '1;
            endcase
          end
          send_request(KIND_ACQUIRE, dev, num, SLOT_W'($urandom_range(0, 15)));
        end
      end
    end
    wait_all_results();
  endtask

  initial begin
    clk = 1'b0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_kind = KIND_ACQUIRE;
    in_device = '0;
    in_number = '0;
    in_release_slot = '0;
    out_stall = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      tbl_device[i] = '0;
      tbl_number[i] = '0;
      tbl_count[i] = '0;
    end
    mounts[0] = '0;
    mounts[1] = '0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_basic_requests();
    test_table_full();
    test_mount_redirect();
    test_count_overflow();
    test_random_traffic();

    wait_all_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Sent %0d requests (basic, full, mount, overflow, random); %0d results checked.",
             requests_sent, results_checked);
    $display("By status: hit %0d, load %0d, full %0d, rel %0d, last %0d, bad %0d, ovf %0d.",
             status_seen[ST_HIT], status_seen[ST_LOAD], status_seen[ST_FULL],
             status_seen[ST_REL], status_seen[ST_LAST], status_seen[ST_BAD],
             status_seen[ST_OVF]);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

FILE: files.f
+incdir+sv
sv/ret_pkg.sv
sv/ret_regs.sv
sv/ret_dp.sv
sv/ret_ctrl.sv
sv/refcounted_entry_table_top.sv
dv/tb_refcounted_entry_table_top.sv
